@@ hw/rtl/pulse_triangle_noise_tone_gen_core_assert.svh @@
// Assertion helpers for the tone generator core.
`ifndef PULSE_TRIANGLE_NOISE_TONE_GEN_CORE_ASSERT_SVH
`define PULSE_TRIANGLE_NOISE_TONE_GEN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTNG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ptng_pkg.sv @@
package ptng_pkg;

  // request kinds on in_tuser
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [1:0] OP_KEY_OFF  = 2'd2;

  // waveform codes
  localparam logic [1:0] WAVE_PULSE = 2'd0;
  localparam logic [1:0] WAVE_TRI   = 2'd1;
  localparam logic [1:0] WAVE_NOISE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WAVEFORM    = 2'd0;
  localparam logic [1:0] REG_DUTY_SELECT = 2'd1;
  localparam logic [1:0] REG_SHORT_MODE  = 2'd2;
  localparam logic [1:0] REG_NOISE_STEP  = 2'd3;

  localparam logic [15:0] NOISE_STEP_RST = 16'd10389;

  localparam int STEP_W  = 24;
  localparam int NOTE_W  = 7;
  localparam int VOL_W   = 8;
  localparam int LEVEL_W = 4;
  localparam int OUT_W   = 16;
  localparam int PER_W   = 12;

  // scale = |2*level-15| * volume * 32767 / 3825
  localparam int M_W         = 12;
  localparam int X_W         = 27;
  localparam int Q_W         = 16;
  localparam int SCALE_DIV   = 15 * 255;
  localparam int SCALE_SHIFT = 32;
  localparam int RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] SCALE_RECIP =
    RECIP_W'((64'd1 << SCALE_SHIFT) / SCALE_DIV);

  localparam logic [7:0] DUTY_BITS [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};

  localparam logic [LEVEL_W-1:0] TRI_RAMP [32] = '{
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};

  localparam logic [PER_W-1:0] NOISE_PERIODS [16] = '{
    12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
    12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068};

  typedef struct packed {
    logic note_on;
    logic key_off;
    logic tick;
    logic mul_m;
    logic mul_x;
    logic mul_q;
    logic mul_p;
    logic fix;
    logic lfsr_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic noise_sel;
    logic cnt_le0;
  } status_t;

endpackage

@@ hw/rtl/ptng_ctrl.sv @@
module ptng_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic [1:0]         in_op,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  ptng_pkg::status_t  status,
  output ptng_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_XMUL  = 3'd2;
  localparam logic [2:0] S_QMUL  = 3'd3;
  localparam logic [2:0] S_PMUL  = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_NOISE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign acc        = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.note_on  = acc && (in_op == ptng_pkg::OP_NOTE_ON);
        cmd.key_off  = acc && (in_op == ptng_pkg::OP_KEY_OFF);
        cmd.tick     = acc && (in_op == ptng_pkg::OP_TICK);
        if (cmd.tick) begin
          state_nxt = status.active ? S_MUL : S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_m = 1'b1;
        state_nxt = S_XMUL;
      end
      S_XMUL: begin
        cmd.mul_x = 1'b1;
        state_nxt = S_QMUL;
      end
      S_QMUL: begin
        cmd.mul_q = 1'b1;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.mul_p = 1'b1;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = status.noise_sel ? S_NOISE : S_OUT;
      end
      S_NOISE: begin
        // one timer reload and one shift per cycle until the timer is positive
        if (status.cnt_le0) begin
          cmd.lfsr_step = 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/ptng_datapath.sv @@
module ptng_datapath #(
  parameter int PHASE_BITS      = 24,
  parameter int TIMER_FRAC_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ptng_pkg::cmd_t                         cmd,
  input  logic [ptng_pkg::STEP_W-1:0]            in_phase_step,
  input  logic [ptng_pkg::NOTE_W-1:0]            in_note_number,
  input  logic [ptng_pkg::VOL_W-1:0]             in_velocity,
  input  logic                                   cfg_wr_en,
  input  logic [1:0]                             cfg_addr,
  input  logic [15:0]                            cfg_wdata,
  output ptng_pkg::status_t                      status,
  output logic [ptng_pkg::LEVEL_W-1:0]           out_level,
  output logic signed [ptng_pkg::OUT_W-1:0]      out_scaled,
  output logic                                   out_sounding
);

  // timer holds the longest period plus fraction, and one noise step below zero
  localparam int CNT_MAG = (ptng_pkg::PER_W + 1 + TIMER_FRAC_BITS > 17) ?
                           (ptng_pkg::PER_W + 1 + TIMER_FRAC_BITS) : 17;
  localparam int CNT_W   = CNT_MAG + 1;

  // configuration
  logic [1:0]  wave_r, wave_nxt;
  logic [1:0]  duty_r, duty_nxt;
  logic        short_r, short_nxt;
  logic [15:0] nstep_r, nstep_nxt;

  // voice state
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]   step_r, step_nxt;
  logic [14:0]             lfsr_r, lfsr_nxt;
  logic signed [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]              nidx_r, nidx_nxt;
  logic [7:0]              vol_r, vol_nxt;
  logic                    active_r, active_nxt;

  // per-sample work registers
  logic [ptng_pkg::LEVEL_W-1:0] level_r;
  logic                         neg_r;
  logic [3:0]                   mag_r;
  logic                         sounding_r;
  logic [ptng_pkg::M_W-1:0]     m_r;
  logic [ptng_pkg::X_W-1:0]     x_r;
  logic [ptng_pkg::Q_W-1:0]     q_r;
  logic [ptng_pkg::X_W-1:0]     p_r;

  logic [ptng_pkg::LEVEL_W-1:0] lvl;
  logic [2:0]                   p3;
  logic [4:0]                   tri_idx;
  logic [3:0]                   new_idx;
  logic signed [CNT_W-1:0]      reload_cur;
  logic signed [CNT_W-1:0]      reload_new;
  logic                         fb;
  logic [ptng_pkg::X_W-1:0]     rem;

  assign p3      = phase_r[PHASE_BITS-1 -: 3];
  assign tri_idx = phase_r[PHASE_BITS-1 -: 5];
  assign new_idx = ~in_note_number[3:0];

  assign reload_cur = $signed(CNT_W'(ptng_pkg::NOISE_PERIODS[nidx_r]) << TIMER_FRAC_BITS);
  assign reload_new = $signed(CNT_W'(ptng_pkg::NOISE_PERIODS[new_idx]) << TIMER_FRAC_BITS);

  assign fb  = lfsr_r[0] ^ (short_r ? lfsr_r[6] : lfsr_r[1]);
  assign rem = x_r - p_r;

  always_comb begin
    case (wave_r)
      ptng_pkg::WAVE_PULSE: lvl = ptng_pkg::DUTY_BITS[duty_r][3'd7 - p3] ? 4'd15 : 4'd0;
      ptng_pkg::WAVE_TRI:   lvl = ptng_pkg::TRI_RAMP[tri_idx];
      ptng_pkg::WAVE_NOISE: lvl = lfsr_r[0] ? 4'd0 : 4'd15;
      default:              lvl = 4'd0;
    endcase
  end

  always_comb begin
    wave_nxt   = wave_r;
    duty_nxt   = duty_r;
    short_nxt  = short_r;
    nstep_nxt  = nstep_r;
    phase_nxt  = phase_r;
    step_nxt   = step_r;
    lfsr_nxt   = lfsr_r;
    cnt_nxt    = cnt_r;
    nidx_nxt   = nidx_r;
    vol_nxt    = vol_r;
    active_nxt = active_r;

    if (cfg_wr_en) begin
      case (cfg_addr)
        ptng_pkg::REG_WAVEFORM:    wave_nxt  = cfg_wdata[1:0];
        ptng_pkg::REG_DUTY_SELECT: duty_nxt  = cfg_wdata[1:0];
        ptng_pkg::REG_SHORT_MODE:  short_nxt = cfg_wdata[0];
        ptng_pkg::REG_NOISE_STEP:  nstep_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (cmd.note_on) begin
      step_nxt   = PHASE_BITS'(in_phase_step);
      nidx_nxt   = new_idx;
      cnt_nxt    = reload_new;
      vol_nxt    = in_velocity;
      active_nxt = 1'b1;
    end
    if (cmd.key_off) begin
      active_nxt = 1'b0;
    end

    if (cmd.tick && active_r) begin
      if (wave_r == ptng_pkg::WAVE_NOISE) begin
        cnt_nxt = cnt_r - $signed(CNT_W'(nstep_r));
      end else begin
        phase_nxt = phase_r + step_r;
      end
    end

    if (cmd.lfsr_step) begin
      cnt_nxt  = cnt_r + reload_cur;
      lfsr_nxt = {fb, lfsr_r[14:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r   <= ptng_pkg::WAVE_PULSE;
      duty_r   <= 2'd0;
      short_r  <= 1'b0;
      nstep_r  <= ptng_pkg::NOISE_STEP_RST;
      phase_r  <= '0;
      step_r   <= '0;
      lfsr_r   <= 15'd1;
      cnt_r    <= '0;
      nidx_r   <= 4'd0;
      vol_r    <= 8'd0;
      active_r <= 1'b0;
    end else begin
      wave_r   <= wave_nxt;
      duty_r   <= duty_nxt;
      short_r  <= short_nxt;
      nstep_r  <= nstep_nxt;
      phase_r  <= phase_nxt;
      step_r   <= step_nxt;
      lfsr_r   <= lfsr_nxt;
      cnt_r    <= cnt_nxt;
      nidx_r   <= nidx_nxt;
      vol_r    <= vol_nxt;
      active_r <= active_nxt;
    end
  end

  // scaling chain: |2L-15| is odd, built from the low level bits
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      level_r    <= active_r ? lvl : 4'd0;
      sounding_r <= active_r;
      neg_r      <= ~lvl[3];
      mag_r      <= lvl[3] ? {lvl[2:0], 1'b1} : {~lvl[2:0], 1'b1};
    end
    if (cmd.mul_m) begin
      m_r <= ptng_pkg::M_W'(mag_r) * ptng_pkg::M_W'(vol_r);
    end
    if (cmd.mul_x) begin
      x_r <= (ptng_pkg::X_W'(m_r) << 15) - ptng_pkg::X_W'(m_r);
    end
    if (cmd.mul_q) begin
      q_r <= ptng_pkg::Q_W'((48'(x_r) * 48'(ptng_pkg::SCALE_RECIP)) >> ptng_pkg::SCALE_SHIFT);
    end
    if (cmd.mul_p) begin
      p_r <= ptng_pkg::X_W'(q_r) * ptng_pkg::X_W'(ptng_pkg::SCALE_DIV);
    end
    if (cmd.fix && (rem >= ptng_pkg::X_W'(ptng_pkg::SCALE_DIV))) begin
      q_r <= q_r + 16'd1;
    end
    if (cmd.load_out) begin
      out_level    <= level_r;
      out_sounding <= sounding_r;
      if (!sounding_r) begin
        out_scaled <= '0;
      end else if (neg_r) begin
        out_scaled <= $signed(16'd0 - q_r);
      end else begin
        out_scaled <= $signed(q_r);
      end
    end
  end

  assign status.active    = active_r;
  assign status.noise_sel = (wave_r == ptng_pkg::WAVE_NOISE);
  assign status.cnt_le0   = cnt_r[CNT_W-1] || (cnt_r == '0);

endmodule

@@ hw/rtl/pulse_triangle_noise_tone_gen_core.sv @@
// Pulse / triangle / noise tone generator.
// Input stream: in_tuser carries the request kind (sample tick, note on,
// note off); in_tdata carries phase step, note number and velocity, used by
// note on only. Note on and note off give no result.
// Each sample tick gives exactly one result on the output stream: the 4-bit
// waveform level, the volume-scaled signed sample, and a sounding flag.
// A tick runs the scaling as a chain of four registered multiplies and one
// correction step, then goes to the output state; noise adds a state after the
// correction that takes one shift-register step per timer reload that the timer
// runs through in that sample (large noise_step against short periods can mean
// many steps). A silent tick goes straight to the output state. in_tready is high
// only while the controller is idle, one request at a time: a tick keeps it busy
// until its result is loaded; note requests are taken every cycle. The output
// register holds a finished result while the receiver stalls; the next request
// is still taken, and its result waits in the last state. Reset (rst_n low,
// synchronous) silences the voice, restores register defaults and seeds the
// noise shift register with one. Configuration writes go through cfg_wr_en /
// cfg_addr / cfg_wdata; the user writes only while idle, unchecked by the block.
`include "pulse_triangle_noise_tone_gen_core_assert.svh"

module pulse_triangle_noise_tone_gen_core #(
  parameter int PHASE_BITS      = 24,
  parameter int TIMER_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: phase_step[23:0], note_number[30:24], velocity[38:31], zero pad[39]
  input  logic [39:0] in_tdata,
  // in_tuser: op[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: level[3:0], scaled[19:4], zero pad[23:20]
  output logic [23:0] out_tdata,
  // out_tuser: sounding[0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  ptng_pkg::cmd_t    cmd;
  ptng_pkg::status_t status;

  logic [ptng_pkg::LEVEL_W-1:0]      level;
  logic signed [ptng_pkg::OUT_W-1:0] scaled;

  ptng_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  ptng_datapath #(
    .PHASE_BITS      (PHASE_BITS),
    .TIMER_FRAC_BITS (TIMER_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_phase_step  (in_tdata[23:0]),
    .in_note_number (in_tdata[30:24]),
    .in_velocity    (in_tdata[38:31]),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .status         (status),
    .out_level      (level),
    .out_scaled     (scaled),
    .out_sounding   (out_tuser)
  );

  // pack the result; pad bits stay zero
  assign out_tdata = {4'd0, scaled, level};

  // a silent sample carries zero level and zero value
  `PTNG_ASSERT_NOW(a_silent_zero, out_tvalid && !out_tuser, out_tdata[19:0] == 20'd0, "silent result not zero")
  // an upper-half level never scales to a negative sample
  `PTNG_ASSERT_NOW(a_sign_match, out_tvalid && out_tuser && out_tdata[3], !out_tdata[19], "sign does not match level")
  // an accepted tick keeps the controller busy in the next cycle
  `PTNG_ASSERT_NEXT(a_tick_busy, in_tvalid && in_tready && (in_tuser == ptng_pkg::OP_TICK), !in_tready, "tick did not start work")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Request kind and waveform code with no name in the package.
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] WAVE_UNUSED = 2'd3;

  // A noise tick at full timer step against the shortest period runs the shift
  // register up to 64 times, so allow well over that before a register write.
  localparam int SETTLE_CYCLES = 150;
  localparam int LIMIT_CYCLES  = 1_500_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 75;

  localparam logic [7:0] DUTY_TAB [4] = '{8'h40, 8'h60, 8'h78, 8'h9F};
  localparam logic [3:0] RAMP_TAB [32] = '{
    4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8,
    4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0,
    4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};
  localparam int PERIOD_TAB [16] = '{
    4, 8, 16, 32, 64, 96, 128, 160, 202, 254, 380, 508, 762, 1016, 2034, 4068};

  typedef struct {
    logic [1:0]  op;
    logic [23:0] step;
    logic [6:0]  note;
    logic [7:0]  vel;
  } req_t;

  typedef struct {
    logic [3:0]         level;
    logic signed [15:0] scaled;
    logic               sounding;
  } sample_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = ptng_pkg::OP_TICK;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = ptng_pkg::REG_WAVEFORM;
  logic [15:0] cfg_wdata = '0;

  // Pending requests for the driver and samples still owed by the block.
  req_t    req_q[$];
  sample_t sample_q[$];
  req_t    next_req;

  int sent_cnt = 0;
  int taken_cnt = 0;
  int samples_seen = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int in_idle_pct = 38;
  int out_idle_pct = 65;
  int hold_left = 0;
  bit hold_ask = 1'b0;

  // Shadow of the voice: configuration and running state.
  logic [1:0]  wave_sel = ptng_pkg::WAVE_PULSE;
  logic [1:0]  duty_sel = 2'd0;
  logic        short_sel = 1'b0;
  logic [15:0] timer_step = ptng_pkg::NOISE_STEP_RST;
  logic [23:0] phase_acc = '0;
  logic [23:0] held_step = '0;
  logic [14:0] lfsr = 15'd1;
  int          noise_cnt = 0;
  logic [3:0]  noise_idx = '0;
  logic [7:0]  volume = '0;
  logic        note_active = 1'b0;

  pulse_triangle_noise_tone_gen_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("tb: mismatch on sample %0d: %s got %0d want %0d", samples_seen, what, got, want);
    mismatch_cnt++;
  endtask

  // Advance the voice by one accepted request; a tick owes exactly one sample.
  task automatic play_request(input logic [1:0] op, input logic [39:0] data);
    int      lvl;
    int      sc;
    sample_t s;
    case (op)
      ptng_pkg::OP_NOTE_ON: begin
        held_step   = data[23:0];
        noise_idx   = 4'd15 - data[27:24];
        noise_cnt   = PERIOD_TAB[noise_idx] * 256;
        volume      = data[38:31];
        note_active = 1'b1;
      end
      ptng_pkg::OP_KEY_OFF: note_active = 1'b0;
      ptng_pkg::OP_TICK: begin
        if (!note_active) begin
          s.level    = '0;
          s.scaled   = '0;
          s.sounding = 1'b0;
        end else begin
          case (wave_sel)
            ptng_pkg::WAVE_PULSE: lvl = DUTY_TAB[duty_sel][7 - phase_acc[23:21]] ? 15 : 0;
            ptng_pkg::WAVE_TRI:   lvl = RAMP_TAB[phase_acc[23:19]];
            ptng_pkg::WAVE_NOISE: lvl = lfsr[0] ? 0 : 15;
            default:              lvl = 0;
          endcase
          sc = ((2 * lvl - 15) * int'(volume) * 32767) / 3825;
          // Noise holds the phase still and runs the timer instead.
          if (wave_sel == ptng_pkg::WAVE_NOISE) begin
            noise_cnt = noise_cnt - int'(timer_step);
            while (noise_cnt <= 0) begin
              noise_cnt = noise_cnt + PERIOD_TAB[noise_idx] * 256;
              lfsr = {lfsr[0] ^ (short_sel ? lfsr[6] : lfsr[1]), lfsr[14:1]};
            end
          end else begin
            phase_acc = phase_acc + held_step;
          end
          s.level    = lvl[3:0];
          s.scaled   = sc[15:0];
          s.sounding = 1'b1;
        end
        sample_q.push_back(s);
      end
      default: ;
    endcase
  endtask

  task automatic check_sample();
    sample_t s;
    if (sample_q.size() == 0) begin
      report_mismatch("sample with none pending, level", int'(out_tdata[3:0]), -1);
    end else begin
      s = sample_q.pop_front();
      if (out_tdata[3:0] !== s.level)
        report_mismatch("level", int'(out_tdata[3:0]), int'(s.level));
      if (out_tdata[19:4] !== s.scaled)
        report_mismatch("scaled", int'($signed(out_tdata[19:4])), int'(s.scaled));
      if (out_tuser !== s.sounding)
        report_mismatch("sounding", int'(out_tuser), int'(s.sounding));
      if (out_tdata[23:20] !== 4'd0)
        report_mismatch("pad", int'(out_tdata[23:20]), 0);
    end
    samples_seen++;
  endtask

  // Sample at the rising edge: register writes, accepted requests, results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          ptng_pkg::REG_WAVEFORM:    wave_sel   = cfg_wdata[1:0];
          ptng_pkg::REG_DUTY_SELECT: duty_sel   = cfg_wdata[1:0];
          ptng_pkg::REG_SHORT_MODE:  short_sel  = cfg_wdata[0];
          ptng_pkg::REG_NOISE_STEP:  timer_step = cfg_wdata;
          default: ;
        endcase
      end
      // Check before predicting: a result never belongs to the request
      // accepted at the same edge.
      if (out_tvalid && out_tready)
        check_sample();
      if (in_tvalid && in_tready) begin
        play_request(in_tuser, in_tdata);
        taken_cnt++;
      end
    end
  end

  // Driver: hold the current request until taken, then offer the next one
  // or idle at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (sent_cnt == taken_cnt) begin
      if (req_q.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
        next_req = req_q.pop_front();
        in_tuser  <= next_req.op;
        in_tdata  <= {1'b0, next_req.vel, next_req.note, next_req.step};
        in_tvalid <= 1'b1;
        sent_cnt++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random; on request, hold off for a long stretch so
  // the output register fills and the block drops in_tready.
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic queue_request(input logic [1:0] op, input logic [23:0] step,
                               input logic [6:0] note, input logic [7:0] vel);
    req_t r;
    r.op   = op;
    r.step = step;
    r.note = note;
    r.vel  = vel;
    req_q.push_back(r);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Wait until every request is taken and every sample is back, then let
  // the block settle.
  task automatic wait_idle();
    while (!(req_q.size() == 0 && sent_cnt == taken_cnt && sample_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_phase();
    int n;
    int r;
    n = 0;
    while (n < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 70) begin
        queue_request(ptng_pkg::OP_TICK, 24'($urandom), 7'($urandom), 8'($urandom));
        n++;
      end else if (r < 87) begin
        queue_request(ptng_pkg::OP_NOTE_ON,
                      $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(24'h03FFFF)),
                      7'($urandom_range(127)), 8'($urandom_range(255)));
        n++;
      end else if (r < 95) begin
        queue_request(ptng_pkg::OP_KEY_OFF, 24'($urandom), 7'($urandom), 8'($urandom));
        n++;
      end else begin
        // Ignored by the block; does not count toward the phase.
        queue_request(OP_UNUSED, 24'($urandom), 7'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: silent ticks, the unused kind, extremes of every field,
    // note on while sounding, note off.
    queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    queue_request(OP_UNUSED, 24'hFFFFFF, 7'd127, 8'd255);
    queue_request(ptng_pkg::OP_KEY_OFF, 24'h0, 7'd0, 8'd0);
    queue_request(ptng_pkg::OP_TICK, 24'hFFFFFF, 7'd127, 8'd255);
    queue_request(ptng_pkg::OP_NOTE_ON, 24'hFFFFFF, 7'd127, 8'd255);
    repeat (4) queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    queue_request(ptng_pkg::OP_NOTE_ON, 24'h0, 7'd0, 8'd0);
    repeat (2) queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    queue_request(ptng_pkg::OP_NOTE_ON, 24'h080000, 7'd64, 8'd1);
    repeat (3) queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    queue_request(ptng_pkg::OP_KEY_OFF, 24'h0, 7'd0, 8'd0);
    queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    wait_idle();

    // Noise at full timer step on the shortest period, short taps.
    write_reg(ptng_pkg::REG_WAVEFORM, 16'(ptng_pkg::WAVE_NOISE));
    write_reg(ptng_pkg::REG_SHORT_MODE, 16'd1);
    write_reg(ptng_pkg::REG_NOISE_STEP, 16'hFFFF);
    queue_request(ptng_pkg::OP_NOTE_ON, 24'h7FFFFF, 7'd15, 8'd255);
    repeat (2) queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    wait_idle();

    // Zero timer step: the shift register must not move.
    write_reg(ptng_pkg::REG_NOISE_STEP, 16'd0);
    queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);
    wait_idle();

    // Unused waveform: level stays at zero while the phase runs.
    write_reg(ptng_pkg::REG_WAVEFORM, 16'(WAVE_UNUSED));
    repeat (2) queue_request(ptng_pkg::OP_TICK, 24'h0, 7'd0, 8'd0);

    // Random phases: walk every waveform and duty, both tap modes, timer
    // step extremes; receiver-heavy idling, then sender-heavy, then none.
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      in_idle_pct  = (p < 6) ? 38 : (p < 11) ? 65 : 0;
      out_idle_pct = (p < 6) ? 65 : (p < 11) ? 38 : 0;
      write_reg(ptng_pkg::REG_WAVEFORM, 16'(p % 4));
      write_reg(ptng_pkg::REG_DUTY_SELECT, 16'(p / 4));
      write_reg(ptng_pkg::REG_SHORT_MODE, 16'((p / 4) % 2));
      case (p)
        2:       write_reg(ptng_pkg::REG_NOISE_STEP, 16'hFFFF);
        6:       write_reg(ptng_pkg::REG_NOISE_STEP, 16'd1);
        10:      write_reg(ptng_pkg::REG_NOISE_STEP, 16'($urandom_range(1, 4096)));
        default: write_reg(ptng_pkg::REG_NOISE_STEP, 16'($urandom_range(65535)));
      endcase
      if (p == 3 || p == 12)
        hold_ask = 1'b1;
      queue_random_phase();
    end

    while (!(req_q.size() == 0 && sent_cnt == taken_cnt && sample_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
